>>> design/rgb_hsv_color_converter_assert.svh
// Assertion macros used by the checker file.
`ifndef RGB_HSV_COLOR_CONVERTER_ASSERT_SVH
`define RGB_HSV_COLOR_CONVERTER_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define RHC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rgb_hsv_color_converter: assertion failed");

// next-cycle implication, quiet while reset is high
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rgb_hsv_color_converter: assertion failed");

// next-cycle implication, checked through reset too
`define RHC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rgb_hsv_color_converter: assertion failed");

`endif

>>> design/rhc_pkg.sv
package rhc_pkg;

   localparam int CB = 16;
   localparam int Q_W = CB + 1;
   localparam int NUM_W = 2 * CB + 4;
   localparam int DEN_W = CB + 4;
   localparam int DIV_STAGES = Q_W;
   localparam int FRONT_STAGES = 2;
   localparam int H2R_LAT = 5;
   localparam int LAST_STAGE = FRONT_STAGES + DIV_STAGES;
   localparam int RGB_DLY = LAST_STAGE - H2R_LAT;

   localparam logic [CB-1:0] FULL = {CB{1'b1}};
   localparam logic [2*CB-1:0] FULL_HALF = (2*CB)'((1 << (CB - 1)) - 1);
   localparam logic [2*CB-1:0] HUE_HALF = (2*CB)'(1 << (CB - 1));

   typedef struct packed {
      logic [CB-1:0] chan_a;
      logic [CB-1:0] chan_b;
      logic [CB-1:0] chan_c;
   } req_type;

   typedef struct packed {
      logic [CB-1:0] out_a;
      logic [CB-1:0] out_b;
      logic [CB-1:0] out_c;
   } rsp_type;

   // round(prod / FULL), halves up; prod never exceeds FULL * FULL
   function automatic logic [CB-1:0] div_full_round(input logic [2*CB-1:0] prod);
      logic [2*CB-1:0] n;
      logic [CB-1:0] q0;
      logic [CB:0] r;
      logic [CB:0] q;
      n = prod + FULL_HALF;
      q0 = n[2*CB-1:CB];
      r = {1'b0, n[CB-1:0]} + {1'b0, q0};
      q = {1'b0, q0};
      if (r >= {1'b0, FULL}) begin
         q = q + 1'b1;
      end
      if (r >= {FULL, 1'b0}) begin
         q = q + 1'b1;
      end
      return q[CB-1:0];
   endfunction

endpackage

>>> design/rhc_div.sv
module rhc_div (
   input  logic                     clock,
   input  logic                     en,
   input  logic [rhc_pkg::NUM_W-1:0] num_in,
   input  logic [rhc_pkg::DEN_W-1:0] den_in,
   output logic [rhc_pkg::Q_W-1:0]   quo_out
);

   // restoring divider, one quotient bit per stage, MSB first
   logic [rhc_pkg::NUM_W-1:0] rem_ff [rhc_pkg::DIV_STAGES-1];
   logic [rhc_pkg::DEN_W-1:0] den_ff [rhc_pkg::DIV_STAGES-1];
   logic [rhc_pkg::Q_W-1:0]   quo_ff [rhc_pkg::DIV_STAGES];

   for (genvar j = 0; j < rhc_pkg::DIV_STAGES; j++) begin : g_stage
      localparam int BIT = rhc_pkg::Q_W - 1 - j;
      logic [rhc_pkg::NUM_W-1:0] rem_cur;
      logic [rhc_pkg::DEN_W-1:0] den_cur;
      logic [rhc_pkg::Q_W-1:0]   quo_cur;
      logic [rhc_pkg::NUM_W:0]   shifted;
      logic [rhc_pkg::NUM_W:0]   trial;
      logic [rhc_pkg::NUM_W-1:0] rem_in;
      logic [rhc_pkg::Q_W-1:0]   quo_in;

      if (j == 0) begin : g_first
         assign rem_cur = num_in;
         assign den_cur = den_in;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[j-1];
         assign den_cur = den_ff[j-1];
         assign quo_cur = quo_ff[j-1];
      end

      always_comb begin
         shifted = (rhc_pkg::NUM_W+1)'(den_cur) << BIT;
         trial = {1'b0, rem_cur} - shifted;
         rem_in = trial[rhc_pkg::NUM_W] ? rem_cur : trial[rhc_pkg::NUM_W-1:0];
         quo_in = quo_cur;
         quo_in[BIT] = ~trial[rhc_pkg::NUM_W];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[j] <= quo_in;
         end
      end

      if (j < rhc_pkg::DIV_STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= rem_in;
               den_ff[j] <= den_cur;
            end
         end
      end
   end

   assign quo_out = quo_ff[rhc_pkg::DIV_STAGES-1];

endmodule

>>> design/rhc_hsv2rgb.sv
module rhc_hsv2rgb (
   input  logic             clock,
   input  logic             en,
   input  rhc_pkg::req_type hsv_in,
   output rhc_pkg::rsp_type rgb_out
);

   localparam int CB = rhc_pkg::CB;

   logic [CB+2:0]   h6;
   logic [CB:0]     f_c;
   logic [2*CB:0]   py_w;
   logic [2*CB-1:0] sx;
   logic [2*CB-1:0] sy;
   logic [CB-1:0]   n_v;
   logic [CB-1:0]   k_v;
   rhc_pkg::rsp_type rgb_in;

   logic [2:0]      sext1_ff, sext2_ff, sext3_ff, sext4_ff;
   logic [CB-1:0]   f1_ff;
   logic [CB-1:0]   s1_ff;
   logic [CB-1:0]   v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2*CB-1:0] px2_ff, py2_ff, pm2_ff;
   logic [CB-1:0]   x3_ff, y3_ff, m3_ff, m4_ff;
   logic [2*CB-1:0] pn4_ff, pk4_ff;
   rhc_pkg::rsp_type rgb_ff;

   always_comb begin
      h6 = {1'b0, hsv_in.chan_a, 2'b00} + {2'b00, hsv_in.chan_a, 1'b0};
      f_c = {1'b1, {CB{1'b0}}} - {1'b0, f1_ff};
      py_w = (2*CB+1)'(s1_ff) * (2*CB+1)'(f_c);
      sx = px2_ff + rhc_pkg::HUE_HALF;
      sy = py2_ff + rhc_pkg::HUE_HALF;
      n_v = rhc_pkg::div_full_round(pn4_ff);
      k_v = rhc_pkg::div_full_round(pk4_ff);
      case (sext4_ff)
         3'd0: rgb_in = '{out_a: v4_ff, out_b: k_v,   out_c: m4_ff};
         3'd1: rgb_in = '{out_a: n_v,   out_b: v4_ff, out_c: m4_ff};
         3'd2: rgb_in = '{out_a: m4_ff, out_b: v4_ff, out_c: k_v};
         3'd3: rgb_in = '{out_a: m4_ff, out_b: n_v,   out_c: v4_ff};
         3'd4: rgb_in = '{out_a: k_v,   out_b: m4_ff, out_c: v4_ff};
         default: rgb_in = '{out_a: v4_ff, out_b: m4_ff, out_c: n_v};
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // split hue into sextant and fraction
         sext1_ff <= h6[CB+2:CB];
         f1_ff <= h6[CB-1:0];
         s1_ff <= hsv_in.chan_b;
         v1_ff <= hsv_in.chan_c;
         // saturation products
         px2_ff <= (2*CB)'(s1_ff) * (2*CB)'(f1_ff);
         py2_ff <= py_w[2*CB-1:0];
         pm2_ff <= (2*CB)'(v1_ff) * (2*CB)'(rhc_pkg::FULL - s1_ff);
         sext2_ff <= sext1_ff;
         v2_ff <= v1_ff;
         // round x, y and m
         x3_ff <= sx[2*CB-1:CB];
         y3_ff <= sy[2*CB-1:CB];
         m3_ff <= rhc_pkg::div_full_round(pm2_ff);
         sext3_ff <= sext2_ff;
         v3_ff <= v2_ff;
         // value products for n and k
         pn4_ff <= (2*CB)'(v3_ff) * (2*CB)'(rhc_pkg::FULL - x3_ff);
         pk4_ff <= (2*CB)'(v3_ff) * (2*CB)'(rhc_pkg::FULL - y3_ff);
         m4_ff <= m3_ff;
         sext4_ff <= sext3_ff;
         v4_ff <= v3_ff;
         rgb_ff <= rgb_in;
      end
   end

   assign rgb_out = rgb_ff;

endmodule

>>> design/rgb_hsv_color_converter.sv
// Channel  Direction  Handshake              Beat
// req      in         req_valid / req_stall  req_data: chan_a, chan_b, chan_c
// rsp      out        rsp_valid / rsp_stall  rsp_data: out_a, out_b, out_c
// csr      in         csr_wr_en              csr_wr_data: direction (1 bit)
//
// One beat per clock sustained while rsp_stall does not hold the pipe.
// Hue and saturation go through the 17-stage bit-per-stage divider.
// Synchronous active-high reset empties the pipe and clears direction to RGB->HSV.
// rsp_stall holds the pipe only once its last stage is occupied; bubbles close up.
// An output register parts the pipe from rsp, so req is taken while a result waits.
module rgb_hsv_color_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rhc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rhc_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   localparam int CB = rhc_pkg::CB;
   localparam int NUM_W = rhc_pkg::NUM_W;
   localparam int DEN_W = rhc_pkg::DEN_W;

   typedef enum logic [1:0] {
      MAX_RED,
      MAX_GREEN,
      MAX_BLUE
   } max_sel_type;

   // sideband that rides along with the dividers
   typedef struct packed {
      logic          dir;
      logic          mx_zero;
      logic          delta_zero;
      logic [CB-1:0] mx;
   } side_type;

   logic dir_ff;
   logic vld_ff [rhc_pkg::LAST_STAGE+1];
   logic en;
   logic out_load;
   logic rsp_valid_ff;
   rhc_pkg::rsp_type rsp_data_ff;

   // stage 0
   rhc_pkg::req_type in0_ff;
   logic dir0_ff;

   // stage 1
   logic [CB-1:0]   r_c, g_c, b_c;
   logic            red_max, green_max, red_min, green_min;
   max_sel_type     sel_in;
   logic [CB-1:0]   mx_in, mn_in;
   logic signed [CB:0] diff_in;
   logic [CB-1:0]   mx1_ff, delta1_ff;
   max_sel_type     sel1_ff;
   logic signed [CB:0] diff1_ff;
   logic            dir1_ff;

   // stage 2
   logic [CB+2:0]   d6;
   logic [CB+2:0]   base;
   logic signed [CB+3:0] t_s;
   logic [CB+2:0]   t_v;
   logic [NUM_W-1:0] hue_num_ff, sat_num_ff;
   logic [DEN_W-1:0] hue_den_ff, sat_den_ff;

   logic [rhc_pkg::Q_W-1:0] quo_h, quo_s;
   side_type side_ff [rhc_pkg::DIV_STAGES+1];
   rhc_pkg::rsp_type rgb_early;
   rhc_pkg::rsp_type rgb_dly_ff [rhc_pkg::RGB_DLY];
   rhc_pkg::rsp_type hsv_res;
   rhc_pkg::rsp_type result;
   side_type side_last;

   // advance unless the last stage holds a beat that cannot leave
   assign out_load = ~rsp_valid_ff | ~rsp_stall;
   assign en = out_load | ~vld_ff[rhc_pkg::LAST_STAGE];
   assign req_stall = ~en;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= 1'b0;
      end else if (csr_wr_en) begin
         dir_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= rhc_pkg::LAST_STAGE; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= rhc_pkg::LAST_STAGE; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // max, min and the signed difference for the hue fraction
   always_comb begin
      r_c = in0_ff.chan_a;
      g_c = in0_ff.chan_b;
      b_c = in0_ff.chan_c;
      red_max = (r_c >= g_c) && (r_c >= b_c);
      green_max = ~red_max && (g_c >= b_c);
      red_min = (r_c <= g_c) && (r_c <= b_c);
      green_min = ~red_min && (g_c <= b_c);
      if (red_max) begin
         sel_in = MAX_RED;
         mx_in = r_c;
         diff_in = $signed({1'b0, g_c}) - $signed({1'b0, b_c});
      end else if (green_max) begin
         sel_in = MAX_GREEN;
         mx_in = g_c;
         diff_in = $signed({1'b0, b_c}) - $signed({1'b0, r_c});
      end else begin
         sel_in = MAX_BLUE;
         mx_in = b_c;
         diff_in = $signed({1'b0, r_c}) - $signed({1'b0, g_c});
      end
      mn_in = red_min ? r_c : (green_min ? g_c : b_c);
   end

   // sextant base plus difference, then numerators and denominators
   always_comb begin
      d6 = {1'b0, delta1_ff, 2'b00} + {2'b00, delta1_ff, 1'b0};
      unique case (sel1_ff)
         MAX_RED:   base = diff1_ff[CB] ? d6 : '0;
         MAX_GREEN: base = {2'b00, delta1_ff, 1'b0};
         MAX_BLUE:  base = {1'b0, delta1_ff, 2'b00};
         default:   base = '0;
      endcase
      t_s = $signed({1'b0, base}) + (CB+4)'(diff1_ff);
      t_v = t_s[CB+2:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in0_ff <= req_data;
         dir0_ff <= dir_ff;
         mx1_ff <= mx_in;
         delta1_ff <= mx_in - mn_in;
         sel1_ff <= sel_in;
         diff1_ff <= diff_in;
         dir1_ff <= dir0_ff;
         hue_num_ff <= (NUM_W'(t_v) << (CB + 1)) + NUM_W'(d6);
         hue_den_ff <= DEN_W'(d6) << 1;
         sat_num_ff <= (NUM_W'(delta1_ff) << (CB + 1)) - (NUM_W'(delta1_ff) << 1)
                       + NUM_W'(mx1_ff);
         sat_den_ff <= DEN_W'(mx1_ff) << 1;
         side_ff[0] <= '{dir: dir1_ff, mx_zero: (mx1_ff == '0),
                         delta_zero: (delta1_ff == '0), mx: mx1_ff};
         for (int i = 1; i <= rhc_pkg::DIV_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         rgb_dly_ff[0] <= rgb_early;
         for (int i = 1; i < rhc_pkg::RGB_DLY; i++) begin
            rgb_dly_ff[i] <= rgb_dly_ff[i-1];
         end
      end
   end

   rhc_div u_div_hue (
      .clock   (clock),
      .en      (en),
      .num_in  (hue_num_ff),
      .den_in  (hue_den_ff),
      .quo_out (quo_h)
   );

   rhc_div u_div_sat (
      .clock   (clock),
      .en      (en),
      .num_in  (sat_num_ff),
      .den_in  (sat_den_ff),
      .quo_out (quo_s)
   );

   rhc_hsv2rgb u_hsv2rgb (
      .clock   (clock),
      .en      (en),
      .hsv_in  (in0_ff),
      .rgb_out (rgb_early)
   );

   // grey drops hue, black drops saturation; hue wraps at a full circle
   always_comb begin
      side_last = side_ff[rhc_pkg::DIV_STAGES];
      hsv_res.out_a = side_last.delta_zero ? '0 : quo_h[CB-1:0];
      hsv_res.out_b = side_last.mx_zero ? '0 : quo_s[CB-1:0];
      hsv_res.out_c = side_last.mx;
      result = side_last.dir ? rgb_dly_ff[rhc_pkg::RGB_DLY-1] : hsv_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= vld_ff[rhc_pkg::LAST_STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

>>> design/rhc_checker.sv
`include "rgb_hsv_color_converter_assert.svh"

module rhc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rhc_pkg::rsp_type rsp_data
);

   // reset empties the output
   `RHC_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)
   // a held result beat stays put
   `RHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // input backs up only behind a stalled result
   `RHC_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)
   // with the output empty, an offered beat is taken
   `RHC_ASSERT_NOW(a_take_when_empty, req_valid && !rsp_valid, !req_stall)

endmodule

bind rgb_hsv_color_converter rhc_checker u_rhc_checker (.*);

>>> bench/rgb_hsv_color_converter_test.sv
`timescale 1ns / 100ps

module rgb_hsv_color_converter_test;

   localparam int PIPE_CYCLES = 20;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic DIR_TO_HSV = 1'b0;
   localparam logic DIR_TO_RGB = 1'b1;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   rhc_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rhc_pkg::rsp_type rsp_data;
   logic    csr_wr_en;
   logic    csr_wr_data;

   // bench's own copy of the direction register
   logic    model_direction;
   rhc_pkg::rsp_type pixel_queue[$];
   int      mismatch_count;
   int      beats_checked;
   int      cycle_count;
   int      long_hold;

   rgb_hsv_color_converter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // rounded divide, halves up
   function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
      if (den == 0) begin
         return 0;
      end
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic rhc_pkg::rsp_type convert_pixel(rhc_pkg::req_type px, logic dir);
      longint unsigned a, b, c, mx, mn, delta, t, h6, sext, f, x, y, m, n, k, full, one;
      rhc_pkg::rsp_type res;
      full = 64'hFFFF;
      one = 64'h10000;
      a = px.chan_a;
      b = px.chan_b;
      c = px.chan_c;
      if (dir == DIR_TO_HSV) begin
         mx = a;
         mn = a;
         if (b > mx) mx = b;
         if (c > mx) mx = c;
         if (b < mn) mn = b;
         if (c < mn) mn = c;
         delta = mx - mn;
         res.out_c = mx[15:0];
         res.out_b = (mx != 0) ? 16'(round_div(delta * full, mx)) : '0;
         res.out_a = '0;
         if (delta != 0) begin
            // ties go to red, then green
            if (a == mx) begin
               t = (b >= c) ? b - c : 6 * delta - (c - b);
            end else if (b == mx) begin
               t = 2 * delta + c - a;
            end else begin
               t = 4 * delta + a - b;
            end
            res.out_a = 16'(round_div(t * one, 6 * delta));
         end
         return res;
      end
      if (b == 0) begin
         res.out_a = c[15:0];
         res.out_b = c[15:0];
         res.out_c = c[15:0];
         return res;
      end
      h6 = a * 6;
      sext = h6 >> 16;
      f = h6 & full;
      x = round_div(b * f, one);
      y = round_div(b * (one - f), one);
      m = round_div(c * (full - b), full);
      n = round_div(c * (full - x), full);
      k = round_div(c * (full - y), full);
      case (sext)
         0: res = {c[15:0], k[15:0], m[15:0]};
         1: res = {n[15:0], c[15:0], m[15:0]};
         2: res = {m[15:0], c[15:0], k[15:0]};
         3: res = {m[15:0], n[15:0], c[15:0]};
         4: res = {k[15:0], m[15:0], c[15:0]};
         default: res = {c[15:0], m[15:0], n[15:0]};
      endcase
      return res;
   endfunction

   // offer one beat, hold it until taken, then log its expected pixel
   task automatic send_pixel(rhc_pkg::req_type px);
      req_valid <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_stall);
      pixel_queue.push_back(convert_pixel(px, model_direction));
   endtask

   // random length gap between bursts; zero gaps keep valid high
   task automatic send_burst(int count, bit full_range);
      rhc_pkg::req_type px;
      int gap;
      for (int i = 0; i < count; i++) begin
         if (full_range) begin
            px = {16'($urandom), 16'($urandom), 16'($urandom)};
         end else begin
            // bias toward equal channel pairs, near-zero saturation and near-full value
            px = {16'($urandom), 16'($urandom), 16'($urandom)};
            case ($urandom_range(0, 3))
               0: px.chan_b = px.chan_a;
               1: px.chan_c = px.chan_a;
               2: px.chan_b = 16'($urandom_range(0, 3));
               default: px.chan_c = 16'hFFFF - 16'($urandom_range(0, 3));
            endcase
         end
         send_pixel(px);
      end
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain the pipe, then let any stragglers settle before touching the register
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES + 4) @(posedge clock);
   endtask

   task automatic write_direction(logic dir);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= dir;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_direction = dir;
   endtask

   task automatic test_default_direction();
      // reset leaves RGB to HSV selected
      send_pixel({16'h0000, 16'h0000, 16'h0000});
      send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF});
   endtask

   task automatic test_rgb_corners();
      write_direction(DIR_TO_HSV);
      send_pixel({16'hFFFF, 16'h0000, 16'h0000});
      send_pixel({16'h0000, 16'hFFFF, 16'h0000});
      send_pixel({16'h0000, 16'h0000, 16'hFFFF});
      send_pixel({16'hFFFF, 16'h0000, 16'hFFFF});
      send_pixel({16'hFFFF, 16'hFFFF, 16'h0000});
      send_pixel({16'h8000, 16'h8000, 16'h8000});
      send_pixel({16'h0001, 16'h0000, 16'h0000});
      send_pixel({16'hFFFF, 16'hFFFE, 16'hFFFF});
      send_pixel({16'h1234, 16'h1234, 16'h0FFF});
   endtask

   task automatic test_hsv_corners();
      write_direction(DIR_TO_RGB);
      send_pixel({16'h0000, 16'h0000, 16'hFFFF});
      send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_pixel({16'h0000, 16'hFFFF, 16'hFFFF});
      send_pixel({16'h2AAB, 16'hFFFF, 16'hFFFF});
      send_pixel({16'h5555, 16'hFFFF, 16'h8000});
      send_pixel({16'h8000, 16'h8000, 16'hFFFF});
      send_pixel({16'hAAAB, 16'h0001, 16'h0001});
      send_pixel({16'hD555, 16'hFFFF, 16'h0000});
      send_pixel({16'hFFFF, 16'h1234, 16'hFFFF});
   endtask

   task automatic test_random_mix();
      for (int phase = 0; phase < 6; phase++) begin
         write_direction(phase[0] ? DIR_TO_RGB : DIR_TO_HSV);
         for (int k = 0; k < 8; k++) begin
            send_burst($urandom_range(1, 10), $urandom_range(0, 2) != 0);
         end
      end
   endtask

   task automatic test_backpressure();
      // the receiver parks for a long stretch; keep offering beats so input stalls
      long_hold = 120;
      repeat (40) send_pixel({16'($urandom), 16'($urandom), 16'($urandom)});
      wait_idle();
   endtask

   // receiver stall pattern, with quiet stretches and a forced long hold
   initial begin
      rsp_stall = 1'b0;
      long_hold = 0;
      forever begin
         @(posedge clock);
         if (long_hold > 0) begin
            rsp_stall <= 1'b1;
            long_hold--;
         end else if (cycle_count % 512 < 128) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   // compare each beat taken on rsp against the oldest expected pixel
   always @(posedge clock) begin
      rhc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected beat %h", rsp_data);
            end
         end else begin
            want = pixel_queue.pop_front();
            beats_checked++;
            if (want.out_a !== rsp_data.out_a || want.out_b !== rsp_data.out_b
                || want.out_c !== rsp_data.out_c) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("beat %0d: expected a=%h b=%h c=%h, got a=%h b=%h c=%h",
                           beats_checked, want.out_a, want.out_b, want.out_c,
                           rsp_data.out_a, rsp_data.out_b, rsp_data.out_c);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      cycle_count = 0;
      mismatch_count = 0;
      beats_checked = 0;
      model_direction = DIR_TO_HSV;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_default_direction();
      test_rgb_corners();
      test_hsv_corners();
      test_random_mix();
      write_direction(DIR_TO_HSV);
      test_backpressure();
      write_direction(DIR_TO_RGB);
      test_backpressure();
      test_random_mix();
      wait_idle();
      $display("checked %0d pixels in both directions, corner colors and long rsp holds",
               beats_checked);
      if (mismatch_count == 0 && pixel_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d pixels missing", mismatch_count, pixel_queue.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule
